>>> rtl/hsl_pixel_adjust_defines.svh
// assertion macros shared by the hsl pixel adjust rtl
`ifndef HSL_PIXEL_ADJUST_DEFINES_SVH
`define HSL_PIXEL_ADJUST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hpa_pkg.sv
// shared types, constants and helpers of the hsl pixel adjust block
package hpa_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_HUE   = 2'd0;
  localparam logic [1:0] REG_SAT   = 2'd1;
  localparam logic [1:0] REG_LIGHT = 2'd2;

  // reciprocal of 255 for operands below 2^17
  localparam int unsigned RECIP_255   = 131587;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned X_W         = 17;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef struct packed {
    logic signed [8:0] hue;
    logic signed [8:0] sat;
    logic signed [8:0] light;
  } hpa_cfg_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  lum;
    logic        grey;
    logic [15:0] snum;
    logic [8:0]  sden;
    logic [18:0] hnum;
    logic [10:0] hden;
  } hpa_entry_t;

  typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} hpa_seg_t;

  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) res = 8'd0;
    else if (v > 11'sd255) res = 8'd255;
    else res = v[7:0];
    return res;
  endfunction

endpackage

>>> rtl/hpa_if.sv
// pixel stream interfaces for the input and result channels
interface hpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface hpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

>>> rtl/hsl_pixel_adjust.sv
// top level of the hsl pixel adjust block
// Usage:
//   in_px  carries one ABGR pixel per item (alpha 31:24, then B, G, R bytes).
//   out_px returns the adjusted pixel, alpha copied, in the same order.
//   cfg_we/cfg_idx/cfg_data write the hue, saturation and lightness offsets
//   (9-bit signed, index 0, 1, 2); write them only while no item is in flight.
// Throughput: one item per cycle while no result waits on a low out_px.ready.
// Pipeline: the path from acceptance to out_px.valid runs through the
//   eight-stage restoring divider for hue and saturation, the three-stage
//   divide-by-255 units and the four-stage hsl-to-rgb tail.
// Reset: offsets clear to zero (pixels pass unchanged), queue and pipeline
//   empty; no clearing pass, items are taken in the first cycle after reset.
// Stall: a result held on a low out_px.ready freezes the back pipeline;
//   the four-entry queue keeps in_px.ready high until it fills.
module hsl_pixel_adjust #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hpa_in_if.sink      in_px,
  hpa_out_if.source   out_px,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [8:0]  cfg_data
);

  hpa_pkg::hpa_cfg_t   cfg_r;
  hpa_pkg::hpa_entry_t wr_entry, head;
  logic                push, full, pop, head_valid;

  // offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hpa_pkg::REG_HUE:   cfg_r.hue   <= cfg_data;
        hpa_pkg::REG_SAT:   cfg_r.sat   <= cfg_data;
        hpa_pkg::REG_LIGHT: cfg_r.light <= cfg_data;
        default: ;
      endcase
    end
  end

  hpa_front u_front (
    .in_px (in_px),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  hpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (wr_entry),
    .full      (full),
    .pop       (pop),
    .not_empty (head_valid),
    .rdata     (head)
  );

  hpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_px     (out_px)
  );

endmodule

>>> rtl/hpa_front.sv
// front end: accepts pixels and works out min, max, lightness and divide operands
module hpa_front (
  hpa_in_if.sink               in_px,
  input  logic                 full,
  output logic                 push,
  output hpa_pkg::hpa_entry_t  entry
);

  logic [7:0]         r, g, b, mx, mn;
  logic [7:0]         d;
  logic [8:0]         sum;
  logic signed [12:0] t;
  logic [10:0]        tu;

  assign in_px.ready = !full;
  assign push        = in_px.valid && !full;

  // channel extremes
  always_comb begin
    r  = in_px.pixel_in[7:0];
    g  = in_px.pixel_in[15:8];
    b  = in_px.pixel_in[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
  end

  // hue position in units of d, red wins ties
  always_comb begin
    if (mx == r) begin
      t = $signed({5'b0, g}) - $signed({5'b0, b});
      if (t < 0) t = t + $signed(13'(6 * d));
    end else if (mx == g) begin
      t = $signed(13'({d, 1'b0})) + $signed({5'b0, b}) - $signed({5'b0, r});
    end else begin
      t = $signed(13'({d, 2'b0})) + $signed({5'b0, r}) - $signed({5'b0, g});
    end
    tu = t[10:0];
  end

  always_comb begin
    entry.pixel = in_px.pixel_in;
    entry.lum   = sum[8:1];
    entry.grey  = (d == 8'd0);
    entry.snum  = {d, 8'b0} - 16'(d);
    entry.sden  = (sum <= 9'd255) ? sum : 9'd510 - sum;
    entry.hnum  = 19'({tu, 8'b0}) - 19'(tu);
    entry.hden  = 11'({d, 2'b0}) + 11'({d, 1'b0});
  end

endmodule

>>> rtl/hpa_queue.sv
// short item queue between the front end and the back end
`include "hsl_pixel_adjust_defines.svh"
module hpa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hpa_pkg::hpa_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output hpa_pkg::hpa_entry_t rdata
);

  hpa_pkg::hpa_entry_t         mem_r [hpa_pkg::QDEPTH];
  logic [hpa_pkg::QAW-1:0]     wp_r, rp_r;
  logic [hpa_pkg::QAW:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == (hpa_pkg::QAW+1)'(hpa_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  `HPA_ASSERT_IMPL(a_q_bound, 1'b1, cnt_r <= (hpa_pkg::QAW+1)'(hpa_pkg::QDEPTH), "queue overfilled")
  `HPA_ASSERT_IMPL(a_q_pop, pop, not_empty, "pop from empty queue")
  `HPA_ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count lost a push")

endmodule

>>> rtl/hpa_div255.sv
// three-stage floor((x << F) / 255) by reciprocal multiplication
module hpa_div255 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [16:0]          x,
  output logic [FRAC_BITS+8:0] y
);

  localparam int unsigned K  = (1 << FRAC_BITS) / 255;
  localparam int unsigned R  = (1 << FRAC_BITS) % 255;
  localparam int          VW = FRAC_BITS + 9;

  logic [34:0]          p_r;
  logic [16:0]          x1_r;
  logic [9:0]           q0, q0_r;
  logic [7:0]           r0;
  logic [FRAC_BITS:0]   rk_r;
  logic [15:0]          rr_r;
  logic [34:0]          rq;
  logic [VW-1:0]        y_r;

  // split x into 255 * q0 + r0, then scale each part separately
  always_comb begin
    q0 = 10'(p_r >> hpa_pkg::RECIP_SHIFT);
    r0 = 8'(x1_r - ((17'(q0) << 8) - 17'(q0)));
    rq = 35'(rr_r) * 35'(hpa_pkg::RECIP_255);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= 35'(x) * 35'(hpa_pkg::RECIP_255);
      x1_r <= x;
      q0_r <= q0;
      rk_r <= (FRAC_BITS+1)'(32'(r0) * K);
      rr_r <= 16'(32'(r0) * R);
      y_r  <= (VW'(q0_r) << FRAC_BITS) + VW'(rk_r) + VW'(rq >> hpa_pkg::RECIP_SHIFT);
    end
  end

  assign y = y_r;

endmodule

>>> rtl/hpa_back.sv
// back end: hsl divides, offsets, and the fixed-point return to rgb
`include "hsl_pixel_adjust_defines.svh"
module hpa_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpa_pkg::hpa_cfg_t   cfg,
  input  hpa_pkg::hpa_entry_t head,
  input  logic                head_valid,
  output logic                pop,
  hpa_out_if.source           out_px
);

  localparam int VW   = FRAC_BITS + 9;
  localparam int TW   = FRAC_BITS + 4;
  localparam int LAST = 16;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic [LAST:0] vld_r;
  logic          adv;

  // stall the whole line only when the result is held
  assign adv     = !vld_r[LAST] || out_px.ready;
  assign pop     = adv && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAST-1:0], head_valid};
  end

  // side lines carried along the stages
  logic [31:0] px_ln  [0:15];
  logic [7:0]  lum_ln [0:15];
  logic        g_ln   [0:7];
  logic        sz_ln  [8:15];
  logic [7:0]  h_c_r, s_c_r, l_c, s_c, h_c;

  // restoring divide lanes, one quotient bit per stage
  logic [15:0] srem [0:8];
  logic [7:0]  sq   [0:8];
  logic [8:0]  sden [0:8];
  logic [18:0] hrem [0:8];
  logic [7:0]  hq   [0:8];
  logic [10:0] hden [0:8];

  assign srem[0] = head.snum;
  assign sq[0]   = '0;
  assign sden[0] = head.sden;
  assign hrem[0] = head.hnum;
  assign hq[0]   = '0;
  assign hden[0] = head.hden;

  for (genvar k = 0; k < 8; k++) begin : g_div
    localparam int I = 7 - k;
    logic [23:0] sd;
    logic [25:0] hd;
    logic [15:0] srem_nxt;
    logic [18:0] hrem_nxt;
    logic [7:0]  sq_nxt, hq_nxt;
    always_comb begin
      sd       = 24'(sden[k]) << I;
      hd       = 26'(hden[k]) << I;
      srem_nxt = srem[k];
      sq_nxt   = sq[k];
      hrem_nxt = hrem[k];
      hq_nxt   = hq[k];
      if (24'(srem[k]) >= sd) begin
        srem_nxt  = srem[k] - sd[15:0];
        sq_nxt[I] = 1'b1;
      end
      if (26'(hrem[k]) >= hd) begin
        hrem_nxt  = hrem[k] - hd[18:0];
        hq_nxt[I] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        srem[k+1] <= srem_nxt;
        sq[k+1]   <= sq_nxt;
        sden[k+1] <= sden[k];
        hrem[k+1] <= hrem_nxt;
        hq[k+1]   <= hq_nxt;
        hden[k+1] <= hden[k];
      end
    end
  end

  // offsets and clamps, saturation kept at zero for grey
  always_comb begin
    h_c = hpa_pkg::clamp8($signed({3'b000, hq[8]}) + 11'(cfg.hue));
    l_c = hpa_pkg::clamp8($signed({3'b000, lum_ln[7]}) + 11'(cfg.light));
    s_c = g_ln[7] ? 8'd0 : hpa_pkg::clamp8($signed({3'b000, sq[8]}) + 11'(cfg.sat));
  end

  // max channel numerator and hue numerator
  logic [16:0] xhi, xhs, xhi_r, xhs_r;
  logic [8:0]  ls;
  always_comb begin
    ls = 9'(lum_ln[8]) + 9'(s_c_r);
    if (lum_ln[8] <= 8'd127) xhi = 17'(lum_ln[8]) * (17'd255 + 17'(s_c_r));
    else xhi = ((17'(ls) << 8) - 17'(ls)) - 17'(lum_ln[8]) * 17'(s_c_r);
    xhs = (17'(h_c_r) << 2) + (17'(h_c_r) << 1);
  end

  logic [VW-1:0] yhi, yhs;
  hpa_div255 #(.FRAC_BITS(FRAC_BITS)) u_div_hi (.clk, .en(adv), .x(xhi_r), .y(yhi));
  hpa_div255 #(.FRAC_BITS(FRAC_BITS)) u_div_hs (.clk, .en(adv), .x(xhs_r), .y(yhs));

  // max and min levels, per-channel hue positions
  logic [VW-1:0] twol, hi_a, hi_b, lo5;
  logic [TW-1:0] hs, tr, tb;
  logic [VW-1:0] lo5_r, diff5_r;
  logic [TW-1:0] t5_r [3];
  always_comb begin
    twol = VW'(lum_ln[12]) << (FRAC_BITS + 1);
    hi_a = (yhi > twol) ? twol : yhi;
    lo5  = twol - hi_a;
    hi_b = (hi_a < lo5) ? lo5 : hi_a;
    hs   = yhs[TW-1:0];
    tr   = hs + (ONE << 1);
    if (tr >= 3 * (ONE << 1)) tr = tr - 3 * (ONE << 1);
    tb   = (hs >= (ONE << 1)) ? hs - (ONE << 1) : hs + (ONE << 2);
  end

  // segment of the hue-to-channel rule
  hpa_pkg::hpa_seg_t   seg [3];
  logic [FRAC_BITS:0]  frac [3];
  hpa_pkg::hpa_seg_t   seg6_r [3];
  logic [FRAC_BITS:0]  frac6_r [3];
  logic [VW-1:0]       lo6_r, diff6_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (t5_r[c] < ONE) begin
        seg[c]  = hpa_pkg::SEG_RISE;
        frac[c] = (FRAC_BITS+1)'(t5_r[c]);
      end else if (t5_r[c] < 3 * ONE) begin
        seg[c]  = hpa_pkg::SEG_HIGH;
        frac[c] = '0;
      end else if (t5_r[c] < (ONE << 2)) begin
        seg[c]  = hpa_pkg::SEG_FALL;
        frac[c] = (FRAC_BITS+1)'((ONE << 2) - t5_r[c]);
      end else begin
        seg[c]  = hpa_pkg::SEG_LOW;
        frac[c] = '0;
      end
    end
  end

  // ramp products
  logic [VW-1:0] term [3];
  logic [VW-1:0] term7_r [3];
  logic [VW-1:0] lo7_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (seg6_r[c])
        hpa_pkg::SEG_RISE, hpa_pkg::SEG_FALL:
          term[c] = VW'(((VW+FRAC_BITS+1)'(diff6_r) * (VW+FRAC_BITS+1)'(frac6_r[c]))
                        >> FRAC_BITS);
        hpa_pkg::SEG_HIGH: term[c] = diff6_r;
        default:           term[c] = '0;
      endcase
    end
  end

  // channel bytes and final selection
  logic [VW:0]  lvl [3];
  logic [9:0]   ib  [3];
  logic [7:0]   ob  [3];
  logic [31:0]  pix_nxt, pix_r;
  logic         bypass;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lvl[c] = {1'b0, lo7_r} + {1'b0, term7_r[c]};
      ib[c]  = 10'(lvl[c] >> FRAC_BITS);
      ob[c]  = (ib[c] > 10'd255) ? 8'd255 : ib[c][7:0];
    end
    bypass = (cfg.hue == '0) && (cfg.sat == '0) && (cfg.light == '0);
    if (bypass) pix_nxt = px_ln[15];
    else if (sz_ln[15]) pix_nxt = {px_ln[15][31:24], lum_ln[15], lum_ln[15], lum_ln[15]};
    else pix_nxt = {px_ln[15][31:24], ob[2], ob[1], ob[0]};
  end

  // stage registers outside the divide lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      px_ln[0]  <= head.pixel;
      lum_ln[0] <= head.lum;
      g_ln[0]   <= head.grey;
      for (int s = 1; s < 16; s++) begin
        px_ln[s] <= px_ln[s-1];
        if (s != 8) lum_ln[s] <= lum_ln[s-1];
      end
      for (int s = 1; s < 8; s++) g_ln[s] <= g_ln[s-1];
      for (int s = 9; s < 16; s++) sz_ln[s] <= sz_ln[s-1];
      lum_ln[8] <= l_c;
      sz_ln[8]  <= (s_c == 8'd0);
      h_c_r     <= h_c;
      s_c_r     <= s_c;
      xhi_r     <= xhi;
      xhs_r     <= xhs;
      lo5_r     <= lo5;
      diff5_r   <= hi_b - lo5;
      t5_r[0]   <= tr;
      t5_r[1]   <= hs;
      t5_r[2]   <= tb;
      lo6_r     <= lo5_r;
      diff6_r   <= diff5_r;
      seg6_r    <= seg;
      frac6_r   <= frac;
      lo7_r     <= lo6_r;
      term7_r   <= term;
      pix_r     <= pix_nxt;
    end
  end

  assign out_px.valid     = vld_r[LAST];
  assign out_px.pixel_out = pix_r;

  `HPA_ASSERT_NEXT(a_b_stall, !adv, $stable(vld_r), "pipeline moved while stalled")
  `HPA_ASSERT_NEXT(a_b_take, adv && head_valid, vld_r[0], "popped item not entered")
  `HPA_ASSERT_IMPL(a_b_pop, pop, head_valid && (!vld_r[LAST] || out_px.ready),
                   "pop without room")

endmodule
